// ----- design/adaptive_time_step_control_top_assert.svh -----
// assertion macros for the adaptive time step control block
`ifndef ADAPTIVE_TIME_STEP_CONTROL_TOP_ASSERT_SVH
`define ADAPTIVE_TIME_STEP_CONTROL_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define ATSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off during reset
`define ATSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, always active
`define ATSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- design/atsc_pkg.sv -----
// ----------------------------------------------------------------------------
// atsc_pkg
// Types and constants shared by the adaptive time step control block.
// ----------------------------------------------------------------------------
package atsc_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_FCMP,
    S_NPROD,
    S_DIV,
    S_MUL,
    S_MOD,
    S_FIN
  } state_t;

  localparam logic [2:0] REG_SAVE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_STEP_MIN      = 3'd1;
  localparam logic [2:0] REG_STEP_MAX      = 3'd2;
  localparam logic [2:0] REG_FACTOR_MIN    = 3'd3;
  localparam logic [2:0] REG_FACTOR_MAX    = 3'd4;
  localparam logic [2:0] REG_TOLERANCE     = 3'd5;

  localparam logic [63:0] ONE_Q16        = 64'd65536;
  localparam logic [63:0] RST_STEP_MIN   = 64'd4295;
  localparam logic [63:0] RST_STEP_MAX   = 64'h1_0000_0000;
  localparam logic [31:0] RST_FACTOR_MIN = 32'd32768;
  localparam logic [31:0] RST_FACTOR_MAX = 32'd131072;
  localparam logic [31:0] RST_TOLERANCE  = 32'd655;

endpackage

// ----- design/adaptive_time_step_control_top.sv -----
// ----------------------------------------------------------------------------
// adaptive_time_step_control_top
// Tracks the largest relative temperature change over a stream of cells and,
// on the last cell, derives the next time step with factor and bound clamps
// and an optional cut to the next autosave instant.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  input   | in_valid, in_stall, temp_now, temp_before | request into block
//          | last_cell, step_now, time_now             |
//  output  | out_valid, out_stall, step_next, save_now | request out of block
//  config  | cfg_write, cfg_index, cfg_data            | register writes
//
//  each cell is compared with the running maximum in the shared shift-add unit
//  the last cell then adds further steps, each only where it is needed
//  (factor compare, numerator, 32-step divide, 32-step multiply, modulo)
//  in_stall is high whenever the sequencer is not idle
//  the final state waits while a held result is stalled by out_stall
//  rst is synchronous and clears the result valid and the running maximum
module adaptive_time_step_control_top
  import atsc_pkg::*;
#(
  parameter int TEMP_WIDTH = 32,
  parameter int TIME_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [TEMP_WIDTH-1:0] temp_now,
  input  logic signed [TEMP_WIDTH-1:0] temp_before,
  input  logic                         last_cell,
  input  logic        [TIME_WIDTH-1:0] step_now,
  input  logic        [TIME_WIDTH-1:0] time_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [TIME_WIDTH-1:0] step_next,
  output logic                         save_now,
  input  logic                         cfg_write,
  input  logic                   [2:0] cfg_index,
  input  logic        [TIME_WIDTH-1:0] cfg_data
);

  localparam int BW   = TEMP_WIDTH + 1;
  localparam int T32  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int OPW  = (T32 > TEMP_WIDTH) ? T32 : TEMP_WIDTH;
  localparam int SHA  = (BW > 32) ? BW : 32;
  localparam int SHW  = (SHA > TIME_WIDTH) ? SHA : TIME_WIDTH;
  localparam int ACCW = OPW + SHW + 2;
  localparam int RW   = (BW > TIME_WIDTH + 1) ? BW : TIME_WIDTH + 1;
  localparam int CNTW = $clog2(SHW + 1);

  state_t state, state_next;

  logic [TIME_WIDTH-1:0] save_interval, step_min, step_max;
  logic [31:0]           factor_min, factor_max, tolerance;
  logic [TEMP_WIDTH-1:0] max_diff;
  logic [BW-1:0]         max_base;

  logic [TEMP_WIDTH-1:0] diff_r;
  logic [BW-1:0]         base_r;
  logic                  last_r;
  logic [TIME_WIDTH-1:0] dt_r, tnow_r, step_r;
  logic                  save_r;
  logic [31:0]           q;
  logic signed [ACCW-1:0] acc;
  logic [SHW-1:0]        sa, sb;
  logic [RW-1:0]         r;
  logic [CNTW-1:0]       cnt;
  logic                  done;

  // input conditioning
  logic signed [BW-1:0]  ax, bx, dx;
  logic [TEMP_WIDTH-1:0] ma, mb, md_in;
  logic [BW-1:0]         base_in;

  assign ax      = {temp_now[TEMP_WIDTH-1], temp_now};
  assign bx      = {temp_before[TEMP_WIDTH-1], temp_before};
  assign dx      = ax - bx;
  assign ma      = ax[BW-1] ? TEMP_WIDTH'(-ax) : TEMP_WIDTH'(ax);
  assign mb      = bx[BW-1] ? TEMP_WIDTH'(-bx) : TEMP_WIDTH'(bx);
  assign md_in   = dx[BW-1] ? TEMP_WIDTH'(-dx) : TEMP_WIDTH'(dx);
  assign base_in = BW'(ONE_Q16) + BW'((ma < mb) ? ma : mb);

  // shared shift-add unit
  logic [OPW-1:0]        op_a, op_b;
  logic signed [ACCW-1:0] acc_next;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_CMP: begin
        op_a = OPW'(diff_r);
        op_b = OPW'(max_diff);
      end
      S_FCMP: begin
        op_a = OPW'(tolerance);
        op_b = OPW'(factor_max);
      end
      S_NPROD: op_a = OPW'(tolerance);
      S_MUL:   op_a = OPW'(dt_r);
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign acc_next = (acc <<< 1)
                  + (sa[SHW-1] ? ACCW'(op_a) : ACCW'(0))
                  - (sb[SHW-1] ? ACCW'(op_b) : ACCW'(0));

  // shared restoring divide step
  logic [RW:0]   t_div, d_div;
  logic          ge_div;
  logic [RW-1:0] r_next;
  logic [31:0]   q_next, fq;

  assign t_div  = {r, sa[SHW-1]};
  assign d_div  = (state == S_DIV) ? (RW + 1)'(max_diff) : (RW + 1)'(save_interval);
  assign ge_div = (t_div >= d_div);
  assign r_next = ge_div ? RW'(t_div - d_div) : RW'(t_div);
  assign q_next = {q[30:0], ge_div};
  assign fq     = ((q_next > factor_min) ? q_next : factor_min) < factor_max
                ? ((q_next > factor_min) ? q_next : factor_min) : factor_max;

  // results of the unit
  logic                  acc_pos, acc_neg;
  logic [TEMP_WIDTH-1:0] new_md;
  logic [BW-1:0]         new_mb;
  logic [TIME_WIDTH+15:0] prod;
  logic [TIME_WIDTH-1:0] clip, clip_hi, clip_lo, remain;

  assign acc_neg = acc_next[ACCW-1];
  assign acc_pos = !acc_neg && (acc_next != '0);
  assign new_md  = acc_pos ? diff_r : max_diff;
  assign new_mb  = acc_pos ? base_r : max_base;
  assign prod    = acc_next[TIME_WIDTH+31:16];
  assign clip    = (prod[TIME_WIDTH+15:TIME_WIDTH] != '0) ? '1 : prod[TIME_WIDTH-1:0];
  assign clip_hi = (clip > step_max) ? step_max : clip;
  assign clip_lo = (clip_hi < step_min) ? step_min : clip_hi;
  assign remain  = save_interval - r_next[TIME_WIDTH-1:0];
  assign done    = (cnt == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP: begin
        if (done) begin
          if (!last_r) state_next = S_IDLE;
          else if (new_md == '0) state_next = S_MUL;
          else state_next = S_FCMP;
        end
      end
      S_FCMP:  if (done) state_next = acc_neg ? S_NPROD : S_MUL;
      S_NPROD: if (done) state_next = S_DIV;
      S_DIV:   if (done) state_next = S_MUL;
      S_MUL:   if (done) state_next = (save_interval != '0) ? S_MOD : S_FIN;
      S_MOD:   if (done) state_next = S_FIN;
      S_FIN:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      save_interval <= '0;
      step_min      <= TIME_WIDTH'(RST_STEP_MIN);
      step_max      <= TIME_WIDTH'(RST_STEP_MAX);
      factor_min    <= RST_FACTOR_MIN;
      factor_max    <= RST_FACTOR_MAX;
      tolerance     <= RST_TOLERANCE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAVE_INTERVAL: save_interval <= cfg_data;
        REG_STEP_MIN:      step_min      <= cfg_data;
        REG_STEP_MAX:      step_max      <= cfg_data;
        REG_FACTOR_MIN:    factor_min    <= cfg_data[31:0];
        REG_FACTOR_MAX:    factor_max    <= cfg_data[31:0];
        REG_TOLERANCE:     tolerance     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // running maximum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_diff  <= '0;
      max_base  <= BW'(ONE_Q16);
      out_valid <= 1'b0;
    end else begin
      if (state == S_CMP && done) begin
        max_diff <= new_md;
        max_base <= new_mb;
      end
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        max_diff  <= '0;
        max_base  <= BW'(ONE_Q16);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      step_next <= step_r;
      save_now  <= save_r;
    end
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        diff_r <= md_in;
        base_r <= base_in;
        last_r <= last_cell;
        dt_r   <= step_now;
        tnow_r <= time_now;
        acc    <= '0;
        sa     <= SHW'(max_base) << (SHW - BW);
        sb     <= SHW'(base_in) << (SHW - BW);
        cnt    <= CNTW'(TEMP_WIDTH);
      end
      S_CMP: begin
        if (done) begin
          acc    <= '0;
          save_r <= 1'b0;
          if (new_md == '0) begin
            sa  <= SHW'(factor_max) << (SHW - 32);
            sb  <= '0;
            cnt <= CNTW'(31);
          end else begin
            sa  <= SHW'(new_mb) << (SHW - BW);
            sb  <= SHW'(new_md) << (SHW - BW);
            cnt <= CNTW'(TEMP_WIDTH);
          end
        end else begin
          acc <= acc_next;
          sa  <= sa << 1;
          sb  <= sb << 1;
          cnt <= cnt - 1'b1;
        end
      end
      S_FCMP: begin
        if (done) begin
          acc <= '0;
          if (acc_neg) begin
            sa  <= SHW'(max_base) << (SHW - BW);
            sb  <= '0;
            cnt <= CNTW'(TEMP_WIDTH);
          end else begin
            sa  <= SHW'(factor_max) << (SHW - 32);
            sb  <= '0;
            cnt <= CNTW'(31);
          end
        end else begin
          acc <= acc_next;
          sa  <= sa << 1;
          sb  <= sb << 1;
          cnt <= cnt - 1'b1;
        end
      end
      S_NPROD: begin
        if (done) begin
          r   <= RW'(acc_next >>> 32);
          sa  <= SHW'(acc_next[31:0]) << (SHW - 32);
          q   <= '0;
          cnt <= CNTW'(31);
        end else begin
          acc <= acc_next;
          sa  <= sa << 1;
          cnt <= cnt - 1'b1;
        end
      end
      S_DIV: begin
        r <= r_next;
        q <= q_next;
        if (done) begin
          acc <= '0;
          sa  <= SHW'(fq) << (SHW - 32);
          sb  <= '0;
          cnt <= CNTW'(31);
        end else begin
          sa  <= sa << 1;
          cnt <= cnt - 1'b1;
        end
      end
      S_MUL: begin
        if (done) begin
          step_r <= clip_lo;
          r      <= '0;
          sa     <= SHW'(tnow_r) << (SHW - TIME_WIDTH);
          cnt    <= CNTW'(TIME_WIDTH - 1);
        end else begin
          acc <= acc_next;
          sa  <= sa << 1;
          cnt <= cnt - 1'b1;
        end
      end
      S_MOD: begin
        r   <= r_next;
        sa  <= sa << 1;
        cnt <= cnt - 1'b1;
        if (done && step_r >= remain) begin
          step_r <= remain;
          save_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/atsc_checker.sv -----
// ----------------------------------------------------------------------------
// atsc_checker
// Port-level checks for the adaptive time step control block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "adaptive_time_step_control_top_assert.svh"

module atsc_checker
  import atsc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [TIME_WIDTH-1:0] step_next,
  input logic                  save_now
);

  `ATSC_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)
  `ATSC_ASSERT_NEXT(a_busy_after_request, clk, rst, in_valid && !in_stall, in_stall)
  `ATSC_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && out_stall,
                    out_valid && $stable(step_next) && $stable(save_now))
  `ATSC_ASSERT_NOW(a_save_step_nonzero, clk, rst, out_valid && save_now, step_next != '0)

endmodule

bind adaptive_time_step_control_top atsc_checker #(.TIME_WIDTH(TIME_WIDTH)) u_atsc_checker (.*);
